// ===== src/psc_pkg.sv =====
// Shared types and constants for the polynomial sine/cosine pipeline.
// Holds the lane bundle passed between stages and the Q32/Q30 constants.
`default_nettype none

package psc_pkg;

  typedef struct packed {
    logic               valid;
    logic               odd;
    logic signed [31:0] r;
    logic signed [32:0] r2;
    logic signed [31:0] p;
  } lane_t;

  localparam logic signed [35:0] PI_Q32   = 36'sd13493037705;
  localparam logic signed [35:0] PI2_Q32  = 36'sd6746518852;
  localparam logic signed [31:0] RECIP_PI = 32'sd1367130551;

  localparam logic signed [31:0] COEF_A = -32'sd198515;
  localparam logic signed [31:0] COEF_B = 32'sd8924834;
  localparam logic signed [31:0] COEF_C = -32'sd178945024;
  localparam logic signed [31:0] COEF_D = 32'sd1073740816;

endpackage

`default_nettype wire

// ===== src/psc_reduce.sv =====
// Range reduction front end: k estimate, exact remainder, correction and r^2.
// Depends on psc_pkg; feeds a lane_t into the first Horner cell.
`default_nettype none

module psc_reduce #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               req_valid,
  input  wire logic signed [31:0] angle,
  input  wire logic               action,
  output psc_pkg::lane_t          lane_out
);
  import psc_pkg::*;

  localparam int XW  = 60;
  localparam int KW  = 26;
  localparam int SHL = 32 - ANGLE_FRAC_BITS;
  localparam int QSH = 32 + ANGLE_FRAC_BITS;
  localparam logic signed [65:0]   HALF  = 66'sd1 <<< (QSH - 1);
  localparam logic signed [XW-1:0] PI_X  = XW'(PI_Q32);
  localparam logic signed [XW-1:0] PI2_X = XW'(PI2_Q32);
  localparam logic signed [63:0]   RND30 = 64'sd536870912;

  logic signed [XW-1:0] x_c;
  logic signed [63:0]   prod_c;
  logic signed [65:0]   ksum;
  logic signed [65:0]   kshift;
  logic signed [KW+35:0] kp_c;
  logic signed [XW-1:0] rsel;
  logic                 flip;
  logic signed [63:0]   sq_c;
  logic signed [63:0]   sq_rnd;

  logic                 v1, v2, v3, v4, v5, v6;
  logic signed [63:0]   prod1;
  logic signed [XW-1:0] x1, x2, x3;
  logic                 act1;
  logic signed [KW-1:0] k2;
  logic signed [XW-1:0] kp3;
  logic                 odd3, odd4, odd5, odd6;
  logic signed [XW-1:0] rem4;
  logic signed [31:0]   r5, r6;
  logic signed [32:0]   r2_6;

  assign x_c    = (XW'(angle) <<< SHL) + (action ? PI2_X : XW'(0));
  assign prod_c = angle * RECIP_PI;
  assign ksum   = 66'(prod1) + HALF + (act1 ? HALF : 66'sd0);
  assign kshift = ksum >>> QSH;
  assign kp_c   = k2 * PI_Q32;
  assign sq_c   = r5 * r5;
  assign sq_rnd = sq_c + RND30;

  always_comb begin
    rsel = rem4;
    flip = 1'b0;
    if (rem4 > PI2_X) begin
      rsel = rem4 - PI_X;
      flip = 1'b1;
    end else if (rem4 < -PI2_X) begin
      rsel = rem4 + PI_X;
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= prod_c;
      x1    <= x_c;
      act1  <= action;
      k2    <= kshift[KW-1:0];
      x2    <= x1;
      kp3   <= kp_c[XW-1:0];
      x3    <= x2;
      odd3  <= k2[0];
      rem4  <= x3 - kp3;
      odd4  <= odd3;
      r5    <= rsel[33:2];
      odd5  <= odd4 ^ flip;
      r2_6  <= sq_rnd[62:30];
      r6    <= r5;
      odd6  <= odd5;
    end
  end

  assign lane_out = '{valid: v6, odd: odd6, r: r6, r2: r2_6, p: COEF_A};

endmodule

`default_nettype wire

// ===== src/psc_horner_cell.sv =====
// One Horner step: p <= coef + round_q30(r2 * p), over two register stages.
// Depends on psc_pkg for the lane_t bundle.
`default_nettype none

module psc_horner_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic signed [31:0] coef,
  input  wire psc_pkg::lane_t     lane_in,
  output psc_pkg::lane_t          lane_out
);
  import psc_pkg::*;

  localparam logic signed [64:0] RND30 = 65'sd536870912;

  logic signed [64:0] prod_c;
  logic signed [64:0] prod_rnd;

  logic               va, vb;
  logic               oa, ob;
  logic signed [31:0] ra, rb;
  logic signed [32:0] r2a, r2b;
  logic signed [64:0] proda;
  logic signed [31:0] pb;

  assign prod_c   = lane_in.r2 * lane_in.p;
  assign prod_rnd = proda + RND30;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= lane_in.valid;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oa    <= lane_in.odd;
      ra    <= lane_in.r;
      r2a   <= lane_in.r2;
      proda <= prod_c;
      ob    <= oa;
      rb    <= ra;
      r2b   <= r2a;
      pb    <= coef + prod_rnd[61:30];
    end
  end

  assign lane_out = '{valid: vb, odd: ob, r: rb, r2: r2b, p: pb};

endmodule

`default_nettype wire

// ===== src/psc_finish.sv =====
// Final r*p product, sign by k parity, output rounding, saturation and skid.
// Depends on psc_pkg; drives the result channel and the pipeline enable.
`default_nettype none

module psc_finish #(
  parameter int RESULT_FRAC_BITS = 30
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire psc_pkg::lane_t     lane_in,
  output logic                    en,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic signed [31:0]      value
);
  import psc_pkg::*;

  localparam int SHIFT = 30 - RESULT_FRAC_BITS;
  localparam logic signed [63:0] RND30   = 64'sd536870912;
  localparam logic signed [33:0] RND_OUT = (SHIFT > 0) ? (34'sd1 <<< (SHIFT - 1)) : 34'sd0;
  localparam logic signed [33:0] ONE     = 34'sd1 <<< RESULT_FRAC_BITS;

  logic signed [63:0] prod_c;
  logic signed [63:0] prod_rnd;
  logic signed [33:0] yr;
  logic signed [31:0] sat_c;

  logic               v1, v2, v3;
  logic               odd1, odd2;
  logic signed [63:0] prod1;
  logic signed [31:0] y2;
  logic signed [32:0] yn3;
  logic               skid_full;
  logic signed [31:0] skid_value;

  assign en       = !skid_full;
  assign prod_c   = lane_in.r * lane_in.p;
  assign prod_rnd = prod1 + RND30;
  assign yr       = (34'(yn3) + RND_OUT) >>> SHIFT;

  always_comb begin
    if (yr > ONE) begin
      sat_c = ONE[31:0];
    end else if (yr < -ONE) begin
      sat_c = 32'(-ONE);
    end else begin
      sat_c = yr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= lane_in.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= prod_c;
      odd1  <= lane_in.odd;
      y2    <= prod_rnd[61:30];
      odd2  <= odd1;
      yn3   <= odd2 ? -33'(y2) : 33'(y2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      if (skid_full) begin
        res_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        res_valid <= v3;
      end
    end else if (v3 && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      value <= skid_full ? skid_value : sat_c;
    end
    if (res_valid && res_stall && !skid_full) begin
      skid_value <= sat_c;
    end
  end

endmodule

`default_nettype wire

// ===== src/poly_sine_cosine.sv =====
// Top level of the polynomial sine/cosine pipeline.
// Depends on psc_pkg, psc_reduce, psc_horner_cell and psc_finish.
//
// Request channel: angle (signed, ANGLE_FRAC_BITS fraction bits) and action
// (0 sine, 1 cosine), taken at a clock edge where req_valid is high and
// req_stall is low. Result channel: value (signed, RESULT_FRAC_BITS fraction
// bits, saturated to +/-1.0), taken where res_valid is high and res_stall low.
// One result per request, in request order.
// Throughput: one request per cycle while req_stall is low, set by the fully
// pipelined datapath: range reduction, three two-stage Horner cells and a finish stage.
// Reset (rst, synchronous) empties the pipeline and the output register.
// When the receiver stalls, the result holds and the next result goes into a
// one-entry skid register; once that is full, req_stall rises and the whole
// pipeline holds until the held result is taken.
`default_nettype none

module poly_sine_cosine #(
  parameter int ANGLE_FRAC_BITS  = 16,
  parameter int RESULT_FRAC_BITS = 30
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire logic signed [31:0] angle,
  input  wire logic               action,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic signed [31:0]      value
);
  import psc_pkg::*;

  logic  en;
  lane_t lane0, lane1, lane2, lane3;

  assign req_stall = !en;

  psc_reduce #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .req_valid(req_valid),
    .angle    (angle),
    .action   (action),
    .lane_out (lane0)
  );

  psc_horner_cell u_cell_b (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .coef    (COEF_B),
    .lane_in (lane0),
    .lane_out(lane1)
  );

  psc_horner_cell u_cell_c (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .coef    (COEF_C),
    .lane_in (lane1),
    .lane_out(lane2)
  );

  psc_horner_cell u_cell_d (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .coef    (COEF_D),
    .lane_in (lane2),
    .lane_out(lane3)
  );

  psc_finish #(
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
  ) u_finish (
    .clk      (clk),
    .rst      (rst),
    .lane_in  (lane3),
    .en       (en),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .value    (value)
  );

endmodule

`default_nettype wire
